// ----- hw/rtl/vector_ema_magnitude_log_map_defines.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for vector_ema_magnitude_log_map
// Concurrent implication checks on a clock with a synchronous reset.
// ----------------------------------------------------------------------------
`ifndef VECTOR_EMA_MAGNITUDE_LOG_MAP_DEFINES_SVH
`define VECTOR_EMA_MAGNITUDE_LOG_MAP_DEFINES_SVH

// same-cycle implication
`define VEMLM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define VEMLM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/vemlm_pkg.sv -----
// ----------------------------------------------------------------------------
// vemlm_pkg
// Types and constants shared by the field smoother, its channels and checker.
// ----------------------------------------------------------------------------
`default_nettype none

package vemlm_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int SAMPLE_SHIFT = FRAC_BITS - 8;
   localparam int MAG_SHIFT    = FRAC_BITS - 8;
   localparam int MAG_HALF     = (MAG_SHIFT > 0) ? (1 << (MAG_SHIFT - 1)) : 0;
   localparam int ALPHA_W      = 16;
   localparam int LOG_STEPS    = 16;

   localparam logic [31:0] LN2_Q32  = 32'd2977044472;
   localparam logic [63:0] ROOT_BIT = 64'h4000_0000_0000_0000;

   typedef logic [1:0]         kind_type;
   typedef logic signed [15:0] field_type;
   typedef logic [15:0]        mag_type;
   typedef logic signed [15:0] dia_type;
   typedef logic [1:0]         csr_index_type;
   typedef logic [15:0]        csr_data_type;
   typedef logic signed [31:0] avg_type;

   localparam kind_type KIND_SAMPLE = 2'd0;
   localparam kind_type KIND_FAIL   = 2'd1;
   localparam kind_type KIND_CLEAR  = 2'd2;

   localparam csr_index_type CSR_ALPHA     = 2'd0;
   localparam csr_index_type CSR_SLOPE     = 2'd1;
   localparam csr_index_type CSR_INTERCEPT = 2'd2;

   localparam csr_data_type ALPHA_RESET     = 16'd6236;
   localparam csr_data_type SLOPE_RESET     = 16'hED80;
   localparam csr_data_type INTERCEPT_RESET = 16'd24554;

endpackage

`default_nettype wire

// ----- hw/rtl/vemlm_channel_if.sv -----
// ----------------------------------------------------------------------------
// vemlm channels
// Valid/ready channels for field samples and smoothed results.
// ----------------------------------------------------------------------------
`default_nettype none

interface vemlm_req_if;
   import vemlm_pkg::*;
   logic      valid;
   logic      ready;
   kind_type  kind;
   field_type field_x;
   field_type field_y;
   field_type field_z;
   modport source (output valid, kind, field_x, field_y, field_z, input ready);
   modport sink (input valid, kind, field_x, field_y, field_z, output ready);
endinterface

interface vemlm_rsp_if;
   import vemlm_pkg::*;
   logic    valid;
   logic    ready;
   mag_type magnitude;
   dia_type diameter;
   logic    diameter_valid;
   modport source (output valid, magnitude, diameter, diameter_valid, input ready);
   modport sink (input valid, magnitude, diameter, diameter_valid, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/vector_ema_magnitude_log_map.sv -----
// Sequence: a sample that finds the filter primed first runs the bit-serial EMA
// multiply; every kind then squares each axis in turn and takes the 32-step square
// root, and a zero magnitude skips the log and diameter steps to finish sooner.
// No new sample is taken until the result has moved to the output register.
// Reset: synchronous, active high; averages cleared, filter unprimed,
// registers back to defaults, no result pending.
// ----------------------------------------------------------------------------
// vector_ema_magnitude_log_map
// 3-axis field EMA with vector magnitude and log-law diameter, bit-serial.
// ----------------------------------------------------------------------------
`default_nettype none

module vector_ema_magnitude_log_map (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_we,
   input  vemlm_pkg::csr_index_type csr_index,
   input  vemlm_pkg::csr_data_type  csr_wdata,
   vemlm_req_if.sink               req_ch,
   vemlm_rsp_if.source             rsp_ch
);
   import vemlm_pkg::*;

   typedef enum logic [12:0] {
      S_IDLE  = 13'b0000000000001,
      S_EMA   = 13'b0000000000010,
      S_LOAD  = 13'b0000000000100,
      S_SQR   = 13'b0000000001000,
      S_ROOT  = 13'b0000000010000,
      S_MAG   = 13'b0000000100000,
      S_NORM  = 13'b0000001000000,
      S_LOG   = 13'b0000010000000,
      S_LNMUL = 13'b0000100000000,
      S_LNRND = 13'b0001000000000,
      S_DMUL  = 13'b0010000000000,
      S_DRND  = 13'b0100000000000,
      S_OUT   = 13'b1000000000000
   } state_type;

   state_type state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] axis_ff, axis_in;
   logic primed_ff, primed_in;
   csr_data_type alpha_ff, alpha_in, slope_ff, slope_in, icpt_ff, icpt_in;
   avg_type avg_ff [3];
   avg_type avg_in [3];
   logic signed [49:0] mcand_ff [3];
   logic signed [49:0] mcand_in [3];
   logic signed [49:0] prod_ff [3];
   logic signed [49:0] prod_in [3];
   logic [15:0] alpha_sh_ff, alpha_sh_in;
   logic [63:0] sq_mc_ff, sq_mc_in, sq_acc_ff, sq_acc_in;
   logic [31:0] sq_ml_ff, sq_ml_in;
   logic [63:0] rt_v_ff, rt_v_in, rt_r_ff, rt_r_in, rt_bit_ff, rt_bit_in;
   mag_type mag_ff, mag_in;
   logic dvld_ff, dvld_in;
   logic [3:0] exp_ff, exp_in;
   logic [31:0] lx_ff, lx_in;
   logic [15:0] frac_ff, frac_in;
   logic signed [53:0] p1_ff, p1_in;
   logic signed [29:0] ln_ff, ln_in;
   logic signed [45:0] p2_ff, p2_in;
   dia_type dia_ff, dia_in;
   logic rsp_valid_ff, rsp_valid_in;
   mag_type rsp_mag_ff, rsp_mag_in;
   dia_type rsp_dia_ff, rsp_dia_in;
   logic rsp_dvld_ff, rsp_dvld_in;

   field_type fld [3];
   logic signed [32:0] samp [3];
   logic signed [33:0] diff [3];
   logic signed [49:0] rsum [3];
   logic [31:0] abs_sel;
   logic [63:0] rt_t;
   logic [32:0] mag_rnd, mag_wide;
   logic [63:0] lsq;
   logic [31:0] lxs;
   logic signed [20:0] l2;
   logic signed [53:0] p1_rnd;
   logic signed [46:0] dsum;
   logic signed [22:0] dfull;
   logic req_fire;

   assign fld[0] = req_ch.field_x;
   assign fld[1] = req_ch.field_y;
   assign fld[2] = req_ch.field_z;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && req_ch.ready;

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.magnitude = rsp_mag_ff;
   assign rsp_ch.diameter = rsp_dia_ff;
   assign rsp_ch.diameter_valid = rsp_dvld_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      axis_in = axis_ff;
      primed_in = primed_ff;
      alpha_in = alpha_ff;
      slope_in = slope_ff;
      icpt_in = icpt_ff;
      alpha_sh_in = alpha_sh_ff;
      sq_mc_in = sq_mc_ff;
      sq_ml_in = sq_ml_ff;
      sq_acc_in = sq_acc_ff;
      rt_v_in = rt_v_ff;
      rt_r_in = rt_r_ff;
      rt_bit_in = rt_bit_ff;
      mag_in = mag_ff;
      dvld_in = dvld_ff;
      exp_in = exp_ff;
      lx_in = lx_ff;
      frac_in = frac_ff;
      p1_in = p1_ff;
      ln_in = ln_ff;
      p2_in = p2_ff;
      dia_in = dia_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_mag_in = rsp_mag_ff;
      rsp_dia_in = rsp_dia_ff;
      rsp_dvld_in = rsp_dvld_ff;
      for (int i = 0; i < 3; i++) begin
         avg_in[i] = avg_ff[i];
         mcand_in[i] = mcand_ff[i];
         prod_in[i] = prod_ff[i];
         samp[i] = $signed({{17{fld[i][15]}}, fld[i]}) <<< SAMPLE_SHIFT;
         diff[i] = $signed({samp[i][32], samp[i]}) - $signed({{2{avg_ff[i][31]}}, avg_ff[i]});
         rsum[i] = prod_ff[i] + 50'sd32768;
      end
      abs_sel = avg_ff[axis_ff][31] ? 32'(-avg_ff[axis_ff]) : 32'(avg_ff[axis_ff]);
      rt_t = rt_r_ff + rt_bit_ff;
      mag_rnd = {1'b0, rt_r_ff[31:0]} + 33'(MAG_HALF);
      mag_wide = mag_rnd >> MAG_SHIFT;
      lsq = {32'b0, lx_ff} * {32'b0, lx_ff};
      lxs = lsq[61:30];
      l2 = $signed({1'b0, exp_ff, frac_ff}) - 21'sd524288;
      p1_rnd = p1_ff + 54'sd8388608;
      dsum = 47'(p2_ff) + $signed({{7{icpt_ff[15]}}, icpt_ff, 24'h800000});
      dfull = dsum[46:24];

      if (csr_we) begin
         case (csr_index)
            CSR_ALPHA: alpha_in = csr_wdata;
            CSR_SLOPE: slope_in = csr_wdata;
            CSR_INTERCEPT: icpt_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               sq_acc_in = '0;
               axis_in = '0;
               cnt_in = '0;
               state_in = S_LOAD;
               case (req_ch.kind)
                  KIND_SAMPLE: begin
                     if (primed_ff) begin
                        for (int i = 0; i < 3; i++) begin
                           mcand_in[i] = {{16{diff[i][33]}}, diff[i]};
                           prod_in[i] = '0;
                        end
                        alpha_sh_in = alpha_ff;
                        state_in = S_EMA;
                     end else begin
                        for (int i = 0; i < 3; i++) avg_in[i] = samp[i][31:0];
                     end
                     primed_in = 1'b1;
                  end
                  KIND_CLEAR: begin
                     for (int i = 0; i < 3; i++) avg_in[i] = '0;
                     primed_in = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_EMA: begin
            if (cnt_ff == 5'(ALPHA_W)) begin
               for (int i = 0; i < 3; i++) avg_in[i] = avg_ff[i] + rsum[i][47:16];
               cnt_in = '0;
               state_in = S_LOAD;
            end else begin
               for (int i = 0; i < 3; i++) begin
                  if (alpha_sh_ff[0]) prod_in[i] = prod_ff[i] + mcand_ff[i];
                  mcand_in[i] = mcand_ff[i] <<< 1;
               end
               alpha_sh_in = alpha_sh_ff >> 1;
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_LOAD: begin
            sq_mc_in = {32'b0, abs_sel};
            sq_ml_in = abs_sel;
            cnt_in = '0;
            state_in = S_SQR;
         end
         S_SQR: begin
            if (sq_ml_ff[0]) sq_acc_in = sq_acc_ff + sq_mc_ff;
            sq_mc_in = sq_mc_ff << 1;
            sq_ml_in = sq_ml_ff >> 1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               if (axis_ff == 2'd2) begin
                  rt_v_in = sq_acc_in;
                  rt_r_in = '0;
                  rt_bit_in = ROOT_BIT;
                  state_in = S_ROOT;
               end else begin
                  axis_in = axis_ff + 2'd1;
                  state_in = S_LOAD;
               end
            end
         end
         S_ROOT: begin
            if (rt_v_ff >= rt_t) begin
               rt_v_in = rt_v_ff - rt_t;
               rt_r_in = (rt_r_ff >> 1) + rt_bit_ff;
            end else begin
               rt_r_in = rt_r_ff >> 1;
            end
            rt_bit_in = rt_bit_ff >> 2;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) state_in = S_MAG;
         end
         S_MAG: begin
            mag_in = (|mag_wide[32:16]) ? 16'hFFFF : mag_wide[15:0];
            dvld_in = (mag_in != '0);
            dia_in = '0;
            state_in = dvld_in ? S_NORM : S_OUT;
         end
         S_NORM: begin
            exp_in = '0;
            for (int i = 1; i < 16; i++) begin
               if (mag_ff[i]) exp_in = 4'(i);
            end
            lx_in = {16'b0, mag_ff} << (5'd30 - {1'b0, exp_in});
            frac_in = '0;
            cnt_in = '0;
            state_in = S_LOG;
         end
         S_LOG: begin
            frac_in = {frac_ff[14:0], lxs[31]};
            lx_in = lxs[31] ? (lxs >> 1) : lxs;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(LOG_STEPS - 1)) state_in = S_LNMUL;
         end
         S_LNMUL: begin
            p1_in = 54'(l2) * 54'($signed({1'b0, LN2_Q32}));
            state_in = S_LNRND;
         end
         S_LNRND: begin
            ln_in = p1_rnd[53:24];
            state_in = S_DMUL;
         end
         S_DMUL: begin
            p2_in = 46'($signed(slope_ff)) * 46'(ln_ff);
            state_in = S_DRND;
         end
         S_DRND: begin
            if (dfull > 23'sd32767) dia_in = 16'sh7FFF;
            else if (dfull < -23'sd32768) dia_in = 16'sh8000;
            else dia_in = dfull[15:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_mag_in = mag_ff;
               rsp_dia_in = dia_ff;
               rsp_dvld_in = dvld_ff;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         axis_ff <= '0;
         primed_ff <= 1'b0;
         alpha_ff <= ALPHA_RESET;
         slope_ff <= SLOPE_RESET;
         icpt_ff <= INTERCEPT_RESET;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < 3; i++) avg_ff[i] <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         axis_ff <= axis_in;
         primed_ff <= primed_in;
         alpha_ff <= alpha_in;
         slope_ff <= slope_in;
         icpt_ff <= icpt_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < 3; i++) avg_ff[i] <= avg_in[i];
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         mcand_ff[i] <= mcand_in[i];
         prod_ff[i] <= prod_in[i];
      end
      alpha_sh_ff <= alpha_sh_in;
      sq_mc_ff <= sq_mc_in;
      sq_ml_ff <= sq_ml_in;
      sq_acc_ff <= sq_acc_in;
      rt_v_ff <= rt_v_in;
      rt_r_ff <= rt_r_in;
      rt_bit_ff <= rt_bit_in;
      mag_ff <= mag_in;
      dvld_ff <= dvld_in;
      exp_ff <= exp_in;
      lx_ff <= lx_in;
      frac_ff <= frac_in;
      p1_ff <= p1_in;
      ln_ff <= ln_in;
      p2_ff <= p2_in;
      dia_ff <= dia_in;
      rsp_mag_ff <= rsp_mag_in;
      rsp_dia_ff <= rsp_dia_in;
      rsp_dvld_ff <= rsp_dvld_in;
   end

endmodule

`default_nettype wire

// ----- hw/rtl/vemlm_checker.sv -----
// ----------------------------------------------------------------------------
// vemlm_checker
// Port-level checks on the field smoother, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vector_ema_magnitude_log_map_defines.svh"

module vemlm_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input vemlm_pkg::mag_type rsp_magnitude,
   input vemlm_pkg::dia_type rsp_diameter,
   input logic               rsp_diameter_valid
);
   import vemlm_pkg::*;

   `VEMLM_ASSERT_NEXT(a_busy_after_transfer, clock, reset, req_valid && req_ready, !req_ready, "req ready right after a transfer")
   `VEMLM_ASSERT_NOW(a_dvalid_matches_mag, clock, reset, rsp_valid, rsp_diameter_valid == (rsp_magnitude != '0), "diameter_valid disagrees with magnitude")
   `VEMLM_ASSERT_NOW(a_invalid_dia_zero, clock, reset, rsp_valid && !rsp_diameter_valid, rsp_diameter == '0, "invalid diameter not zero")
   `VEMLM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_magnitude), "stalled result dropped or changed")

endmodule

bind vector_ema_magnitude_log_map vemlm_checker u_vemlm_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_magnitude      (rsp_ch.magnitude),
   .rsp_diameter       (rsp_ch.diameter),
   .rsp_diameter_valid (rsp_ch.diameter_valid)
);

`default_nettype wire
